// ===== src/tmhq_pkg.sv =====
package tmhq_pkg;

  localparam int unsigned Capacity   = 64;
  localparam int unsigned MaxResults = 64;
  localparam int unsigned IdxW       = $clog2(Capacity);
  localparam int unsigned CntW       = $clog2(Capacity + 1);
  localparam int unsigned NumW       = $clog2(MaxResults + 1);
  localparam int unsigned TimeW      = 48;
  localparam int unsigned IdW        = 32;

  typedef enum logic [1:0] {
    KIND_ADDED = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_IDLE  = 2'd2,
    KIND_FULL  = 2'd3
  } kind_e;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_EXPIRE = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [TimeW-1:0] time_ms;
  } cmd_t;

  typedef struct packed {
    logic [TimeW-1:0] deadline;
    logic [IdW-1:0]   id;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    kind_e            kind;
    logic [IdW-1:0]   timer_id;
    logic [TimeW-1:0] deadline_ms;
    logic [CntW-1:0]  remaining;
    logic             last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_CMP,
    ST_ROOT_CHK,
    ST_POP,
    ST_LAST,
    ST_DN,
    ST_DN_L,
    ST_DN_R,
    ST_AFTER,
    ST_EMIT
  } state_e;

endpackage

// ===== src/tmhq_ram.sv =====
module tmhq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tmhq_front.sv =====
module tmhq_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              op_i,
  input  logic [47:0]       time_ms_i,
  output logic              cmd_valid_o,
  output tmhq_pkg::cmd_t    cmd_o,
  input  logic              cmd_take_i
);
  import tmhq_pkg::*;

  cmd_t       buf_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full        = (cnt_q == 2'd2);
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_pop      = cmd_take_i && cmd_valid_o;
  assign cmd_o       = buf_q[rd_q];

  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= '{op: op_e'(op_i), time_ms: time_ms_i};
    end
  end

endmodule

// ===== src/tmhq_back.sv =====
module tmhq_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  tmhq_pkg::cmd_t     cmd_i,
  output logic               cmd_take_o,
  output logic               empty,
  input  logic               pop,
  output tmhq_pkg::result_t  res_o
);
  import tmhq_pkg::*;

  state_e          state_q, state_d, ret_q, ret_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdW-1:0]  idc_q, idc_d;
  logic [NumW-1:0] num_q, num_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [TimeW-1:0] t_q, t_d;
  entry_t          x_q, x_d, lv_q, lv_d;
  result_t         pend_q, pend_d;
  logic            have_q, have_d;

  logic            we, re;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata, rd;
  logic [EntryW-1:0] rd_raw;

  result_t         ob_q [2];
  logic            owr_q, ord_q;
  logic [1:0]      ocnt_q;
  logic            opush, opop, ofull;

  logic [IdxW-1:0] parent;
  logic [IdxW+1:0] lidx, ridx;
  logic            l_ok, r_ok, due;
  logic [CntW-1:0] cnt_m1;

  tmhq_ram #(.Width(EntryW), .Depth(Capacity)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_raw)
  );
  assign rd = entry_t'(rd_raw);

  assign parent = (pos_q - 1'b1) >> 1;
  assign lidx   = {1'b0, pos_q, 1'b1};
  assign ridx   = lidx + 1'b1;
  assign l_ok   = lidx < {1'b0, count_q};
  assign r_ok   = ridx < {1'b0, count_q};
  assign due    = rd.deadline <= t_q;
  assign cnt_m1 = count_q - 1'b1;
  assign ofull  = (ocnt_q == 2'd2);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == OP_ADD) begin
            state_d = (count_q == CntW'(Capacity)) ? ST_EMIT : ST_UP;
          end else begin
            state_d = (count_q == '0) ? ST_EMIT : ST_ROOT_CHK;
          end
        end
      end
      ST_UP:       state_d = (pos_q == '0) ? ST_EMIT : ST_UP_CMP;
      ST_UP_CMP:   state_d = (x_q.deadline < rd.deadline) ? ST_UP : ST_EMIT;
      ST_ROOT_CHK: state_d = (due && !have_q) ? ST_POP : ST_EMIT;
      ST_POP:      state_d = (cnt_m1 == '0) ? ST_AFTER : ST_LAST;
      ST_LAST:     state_d = ST_DN;
      ST_DN:       state_d = l_ok ? ST_DN_L : ST_AFTER;
      ST_DN_L: begin
        if (r_ok) begin
          state_d = ST_DN_R;
        end else begin
          state_d = (rd.deadline < x_q.deadline) ? ST_DN : ST_AFTER;
        end
      end
      ST_DN_R: begin
        state_d = ((lv_q.deadline < x_q.deadline) || (rd.deadline < x_q.deadline)) ?
                  ST_DN : ST_AFTER;
      end
      ST_AFTER: begin
        state_d = ((num_q == NumW'(MaxResults)) || (count_q == '0)) ? ST_EMIT : ST_ROOT_CHK;
      end
      ST_EMIT:     state_d = ofull ? ST_EMIT : ret_q;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d    = count_q;
    idc_d      = idc_q;
    num_d      = num_q;
    pos_d      = pos_q;
    t_d        = t_q;
    x_d        = x_q;
    lv_d       = lv_q;
    pend_d     = pend_q;
    have_d     = have_q;
    ret_d      = ret_q;
    we         = 1'b0;
    waddr      = pos_q;
    wdata      = x_q;
    re         = 1'b0;
    raddr      = '0;
    cmd_take_o = 1'b0;
    opush      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          t_d        = cmd_i.time_ms;
          num_d      = '0;
          have_d     = 1'b0;
          ret_d      = ST_IDLE;
          if (cmd_i.op == OP_ADD) begin
            if (count_q == CntW'(Capacity)) begin
              pend_d = '{KIND_FULL, '0, '0, count_q, 1'b1};
            end else begin
              idc_d   = idc_q + 1'b1;
              x_d     = '{deadline: cmd_i.time_ms, id: idc_q + 1'b1};
              pos_d   = count_q[IdxW-1:0];
              count_d = count_q + 1'b1;
            end
          end else begin
            pend_d = '{KIND_IDLE, '0, '0, count_q, 1'b1};
            re     = 1'b1;
          end
        end
      end
      ST_UP: begin
        if (pos_q == '0) begin
          we     = 1'b1;
          pend_d = '{KIND_ADDED, x_q.id, x_q.deadline, count_q, 1'b1};
        end else begin
          re    = 1'b1;
          raddr = parent;
        end
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (x_q.deadline < rd.deadline) begin
          wdata = rd;
          pos_d = parent;
        end else begin
          pend_d = '{KIND_ADDED, x_q.id, x_q.deadline, count_q, 1'b1};
        end
      end
      ST_ROOT_CHK: begin
        if (due) begin
          if (have_q) begin
            pend_d.last = 1'b0;
            ret_d       = ST_POP;
          end
        end else begin
          pend_d.last = 1'b1;
          ret_d       = ST_IDLE;
        end
      end
      ST_POP: begin
        pend_d  = '{KIND_FIRED, rd.id, rd.deadline, cnt_m1, 1'b0};
        have_d  = 1'b1;
        count_d = cnt_m1;
        num_d   = num_q + 1'b1;
        re      = 1'b1;
        raddr   = cnt_m1[IdxW-1:0];
      end
      ST_LAST: begin
        x_d   = rd;
        pos_d = '0;
      end
      ST_DN: begin
        if (l_ok) begin
          re    = 1'b1;
          raddr = lidx[IdxW-1:0];
        end else begin
          we = 1'b1;
        end
      end
      ST_DN_L: begin
        lv_d = rd;
        if (r_ok) begin
          re    = 1'b1;
          raddr = ridx[IdxW-1:0];
        end else begin
          we = 1'b1;
          if (rd.deadline < x_q.deadline) begin
            wdata = rd;
            pos_d = lidx[IdxW-1:0];
          end
        end
      end
      ST_DN_R: begin
        we = 1'b1;
        if (lv_q.deadline < x_q.deadline) begin
          if (rd.deadline < lv_q.deadline) begin
            wdata = rd;
            pos_d = ridx[IdxW-1:0];
          end else begin
            wdata = lv_q;
            pos_d = lidx[IdxW-1:0];
          end
        end else if (rd.deadline < x_q.deadline) begin
          wdata = rd;
          pos_d = ridx[IdxW-1:0];
        end
      end
      ST_AFTER: begin
        if ((num_q == NumW'(MaxResults)) || (count_q == '0)) begin
          pend_d.last = 1'b1;
          ret_d       = ST_IDLE;
        end else begin
          re = 1'b1;
        end
      end
      ST_EMIT: begin
        opush = !ofull;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      count_q <= '0;
      idc_q   <= '0;
      num_q   <= '0;
      have_q  <= 1'b0;
      owr_q   <= 1'b0;
      ord_q   <= 1'b0;
      ocnt_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      count_q <= count_d;
      idc_q   <= idc_d;
      num_q   <= num_d;
      have_q  <= have_d;
      owr_q   <= opush ? !owr_q : owr_q;
      ord_q   <= opop ? !ord_q : ord_q;
      ocnt_q  <= ocnt_q + {1'b0, opush} - {1'b0, opop};
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    t_q    <= t_d;
    x_q    <= x_d;
    lv_q   <= lv_d;
    pend_q <= pend_d;
    if (opush) begin
      ob_q[owr_q] <= pend_q;
    end
  end

  assign empty = (ocnt_q == 2'd0);
  assign opop  = pop && !empty;
  assign res_o = ob_q[ord_q];

endmodule

// ===== src/timer_min_heap_queue_core.sv =====
// Timer queue holding up to 64 one-shot timers in a binary min-heap by deadline.
// Input channel: push, full, op_i, time_ms_i. A word with op 0 adds a timer whose
// deadline is time_ms_i; a word with op 1 expires every timer due at time_ms_i.
// Result channel: empty, pop and the result fields. An add gives one word (added
// with its new id, or queue full). An expire gives one word per fired timer, at
// most 64, or a single nothing-due word; last_o marks the final word of an item.
// A two-word input queue feeds a heap engine that owns one single-port-read
// heap memory; all heap reads are one per cycle with registered data.
// An add climbs from the new leaf one level at a time, each step waiting on a
// registered parent read; each fired timer moves the last entry to the root and
// sifts it down, each level waiting on registered reads of the children.
// Results wait in a two-word output queue; when the receiver holds pop low that
// queue fills, the engine stops at its next result and input words collect until full is set.
// Reset empties the heap, both queues and restarts timer ids so the first is 1.
module timer_min_heap_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        op_i,
  input  logic [47:0] time_ms_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [31:0] timer_id_o,
  output logic [47:0] deadline_ms_o,
  output logic [6:0]  remaining_o,
  output logic        last_o
);
  import tmhq_pkg::*;

  logic    cmd_valid, cmd_take;
  cmd_t    cmd;
  result_t res;

  tmhq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .time_ms_i   (time_ms_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  tmhq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign kind_o        = res.kind;
  assign timer_id_o    = res.timer_id;
  assign deadline_ms_o = res.deadline_ms;
  assign remaining_o   = res.remaining;
  assign last_o        = res.last;

endmodule
